// ----- rtl/bcrs_pkg.sv -----
// ============================================================================
// bcrs_pkg
// Shared constants, codes and types of the block cache read splitter.
// ============================================================================
package bcrs_pkg;

    localparam int unsigned MAX_BLOCKS  = 65536;
    localparam int unsigned OFFSET_BITS = 40;

    localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
    localparam int unsigned OFF_W  = OFFSET_BITS;
    localparam int unsigned FLEN_W = 40;
    localparam int unsigned LEN_W  = 19;
    localparam int unsigned BLK_W  = 25;
    localparam int unsigned OIB_W  = 24;
    localparam int unsigned TOL_W  = 8;
    localparam int unsigned NW_W   = 24;
    localparam int unsigned END_W  = OFF_W + 1;
    localparam int unsigned WIN_W  = OFF_W + 2;
    localparam int unsigned DIV_W  = (OFF_W > BLK_W + IDX_W - 1) ? OFF_W : BLK_W + IDX_W - 1;
    localparam int unsigned CAP_W  = (END_W > BLK_W + IDX_W) ? END_W : BLK_W + IDX_W;
    localparam int unsigned CNT_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 40;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BLK_W-1:0] MIN_BLOCK     = BLK_W'(8192);
    localparam logic [BLK_W-1:0] MAX_BLOCK     = BLK_W'(16777216);
    localparam logic [BLK_W-1:0] DEFAULT_BLOCK = BLK_W'(1024 * 1024);
    localparam logic [NW_W-1:0]  DEFAULT_NEAR  = NW_W'((1024 * 1024) / 2);
    localparam logic [TOL_W-1:0] DEFAULT_TOL   = TOL_W'(5);
    localparam logic [LEN_W-1:0] MAX_LEN       = LEN_W'(262144);

    localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_TOLERANCE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_WINDOW    = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        ST_OK,
        ST_BEYOND_END,
        ST_NO_CAPACITY
    } status_t;

    typedef enum logic [1:0] {
        ACT_CACHED,
        ACT_FILL,
        ACT_BYPASS
    } action_t;

    typedef enum logic [2:0] {
        K_ERROR,
        K_BYPASS,
        K_EMPTY,
        K_CAPACITY,
        K_SPLIT
    } kind_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_WINDOW,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_DIVIDE,
        B_ALIGN,
        B_LOOKUP,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        kind_t             kind;
        logic [OFF_W-1:0]  start;
        logic [LEN_W-1:0]  len;
    } job_t;

    typedef struct packed {
        logic [FLEN_W-1:0] file_length;
        logic [BLK_W-1:0]  blk;
        logic [TOL_W-1:0]  tol;
        logic [NW_W-1:0]   near_window;
    } cfg_t;

endpackage

// ----- rtl/bcrs_req_if.sv -----
// ============================================================================
// bcrs_req_if
// Read request channel: valid/ready with start offset and length.
// ============================================================================
interface bcrs_req_if;
    import bcrs_pkg::*;

    logic              valid;
    logic              ready;
    logic [OFF_W-1:0]  start_offset;
    logic [LEN_W-1:0]  length;

    modport source (output valid, output start_offset, output length, input ready);
    modport sink   (input valid, input start_offset, input length, output ready);
endinterface

// ----- rtl/bcrs_res_if.sv -----
// ============================================================================
// bcrs_res_if
// Result channel: valid/ready with one segment or verdict per transaction.
// ============================================================================
interface bcrs_res_if;
    import bcrs_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [1:0]        action;
    logic [IDX_W-1:0]  block_num;
    logic [OFF_W-1:0]  fill_offset;
    logic [BLK_W-1:0]  fill_length;
    logic [OIB_W-1:0]  offset_in_block;
    logic [LEN_W-1:0]  segment_length;
    logic              last;

    modport source (output valid, output status, output action, output block_num,
                    output fill_offset, output fill_length, output offset_in_block,
                    output segment_length, output last, input ready);
    modport sink   (input valid, input status, input action, input block_num,
                    input fill_offset, input fill_length, input offset_in_block,
                    input segment_length, input last, output ready);
endinterface

// ----- rtl/bcrs_cfg_if.sv -----
// ============================================================================
// bcrs_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ============================================================================
interface bcrs_cfg_if;
    import bcrs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/bcrs_ram.sv -----
// ============================================================================
// bcrs_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module bcrs_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bcrs_fifo.sv -----
// ============================================================================
// bcrs_fifo
// Short job queue between the classifying front and the splitting back.
// ============================================================================
module bcrs_fifo import bcrs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    job_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/bcrs_front.sv -----
// ============================================================================
// bcrs_front
// Accept requests, run the window detector and classify each request.
// ============================================================================
module bcrs_front import bcrs_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          enable,
    bcrs_req_if.sink      req,
    output logic          job_valid,
    input  logic          job_ready,
    output job_t          job
);

    front_state_t      state_reg, state_next;
    logic [OFF_W-1:0]  start_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [END_W-1:0]  end_reg;
    logic              err_reg;
    logic              near_reg;
    logic [OFF_W-1:0]  prev_off_reg;
    logic [LEN_W-1:0]  prev_len_reg;
    logic [TOL_W-1:0]  jump_reg;

    logic [LEN_W-1:0]  len_c;
    logic [END_W-1:0]  end_c;
    logic [OFF_W-1:0]  lower_c;
    logic [WIN_W-1:0]  upper_c;
    logic              near_c;
    logic              err_c;
    logic [TOL_W-1:0]  jump_next_c;
    logic              random_c;
    logic              cap_c;
    logic              accept;
    logic              push;

    assign len_c  = (req.length > MAX_LEN) ? MAX_LEN : req.length;
    assign accept = req.valid && req.ready;
    assign push   = job_valid && job_ready;

    // window detector terms
    assign end_c   = END_W'(start_reg) + END_W'(len_reg);
    assign err_c   = end_c > END_W'(cfg.file_length);
    assign lower_c = (prev_off_reg > OFF_W'(cfg.near_window))
                   ? prev_off_reg - OFF_W'(cfg.near_window) : '0;
    assign upper_c = WIN_W'(prev_off_reg) + WIN_W'(prev_len_reg) + WIN_W'(cfg.near_window);
    assign near_c  = (WIN_W'(start_reg) <= upper_c) && (WIN_W'(lower_c) <= WIN_W'(end_c));

    // classification terms
    assign jump_next_c = near_reg ? '0 : ((jump_reg == '1) ? jump_reg : jump_reg + 1'b1);
    assign random_c    = (jump_next_c > cfg.tol) && (BLK_W'(len_reg) < (cfg.blk >> 3));
    assign cap_c       = CAP_W'(end_reg - 1'b1) >= (CAP_W'(cfg.blk) << IDX_W);

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        job_valid  = 1'b0;
        job.start  = start_reg;
        job.len    = len_reg;
        if (err_reg)
        begin
            job.kind = K_ERROR;
        end
        else if (random_c)
        begin
            job.kind = K_BYPASS;
        end
        else if (len_reg == '0)
        begin
            job.kind = K_EMPTY;
        end
        else if (cap_c)
        begin
            job.kind = K_CAPACITY;
        end
        else
        begin
            job.kind = K_SPLIT;
        end

        case (state_reg)
            F_IDLE:
            begin
                req.ready = enable;
                if (accept)
                begin
                    state_next = F_WINDOW;
                end
            end
            F_WINDOW:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                job_valid = 1'b1;
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg <= req.start_offset;
            len_reg   <= len_c;
        end
        if (state_reg == F_WINDOW)
        begin
            end_reg  <= end_c;
            err_reg  <= err_c;
            near_reg <= near_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            prev_off_reg <= '0;
            prev_len_reg <= '0;
            jump_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // a request beyond the file end leaves the window untouched
            if (push && !err_reg)
            begin
                jump_reg     <= jump_next_c;
                prev_off_reg <= start_reg;
                prev_len_reg <= len_reg;
            end
        end
    end

endmodule

// ----- rtl/bcrs_back.sv -----
// ============================================================================
// bcrs_back
// Divide the start offset by the block size, walk the touched blocks and
// emit one result per segment, tracking block presence in a RAM.
// ============================================================================
module bcrs_back import bcrs_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    output logic          ready_for_requests,
    input  logic          job_valid,
    output logic          job_ready,
    input  job_t          job,
    bcrs_res_if.source    res
);

    back_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [OFF_W-1:0]   start_reg;
    logic [LEN_W-1:0]   remaining_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   dsr_reg;
    logic [IDX_W-1:0]   q_reg;
    logic [CNT_W-1:0]   bit_cnt_reg;
    logic [OIB_W-1:0]   oib_reg;
    logic [OFF_W-1:0]   bstart_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    action_t            out_action_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic [OFF_W-1:0]   out_foff_reg;
    logic [BLK_W-1:0]   out_flen_reg;
    logic [OIB_W-1:0]   out_oib_reg;
    logic [LEN_W-1:0]   out_seg_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               load_single;
    logic               load_seg;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic               ram_wdata;
    logic               ram_re;
    logic               present;

    logic               ge_c;
    logic [DIV_W-1:0]   diff_c;
    logic [BLK_W-1:0]   room_c;
    logic [LEN_W-1:0]   seg_c;
    logic [LEN_W-1:0]   rem_after_c;
    logic [OFF_W-1:0]   tail_c;
    logic [BLK_W-1:0]   flen_c;

    bcrs_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_presence (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_reg),
        .rdata (present)
    );

    assign out_free           = !out_valid_reg || res.ready;
    assign ready_for_requests = (state_reg != B_CLEAR);

    // one restoring step per cycle
    assign ge_c   = rem_reg >= dsr_reg;
    assign diff_c = rem_reg - dsr_reg;

    // segment geometry
    assign room_c      = cfg.blk - BLK_W'(oib_reg);
    assign seg_c       = (room_c > BLK_W'(remaining_reg)) ? remaining_reg : LEN_W'(room_c);
    assign rem_after_c = remaining_reg - seg_c;
    assign tail_c      = (bstart_reg > OFF_W'(cfg.file_length))
                       ? '0 : OFF_W'(cfg.file_length) - bstart_reg;
    assign flen_c      = (tail_c < OFF_W'(cfg.blk)) ? BLK_W'(tail_c) : cfg.blk;

    always_comb
    begin
        state_next  = state_reg;
        job_ready   = 1'b0;
        load_single = 1'b0;
        load_seg    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = q_reg;
        ram_wdata   = 1'b1;
        ram_re      = 1'b0;

        case (state_reg)
            B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = 1'b0;
                if (clr_cnt_reg == IDX_W'(MAX_BLOCKS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                job_ready = out_free;
                if (job_valid && out_free)
                begin
                    if (job.kind == K_SPLIT)
                    begin
                        state_next = B_DIVIDE;
                    end
                    else
                    begin
                        load_single = 1'b1;
                    end
                end
            end
            B_DIVIDE:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = B_ALIGN;
                end
            end
            B_ALIGN:
            begin
                state_next = B_LOOKUP;
            end
            B_LOOKUP:
            begin
                ram_re     = 1'b1;
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    load_seg = 1'b1;
                    ram_we   = 1'b1;
                    state_next = (rem_after_c == '0) ? B_IDLE : B_LOOKUP;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && job_valid && out_free)
        begin
            start_reg     <= job.start;
            remaining_reg <= job.len;
            rem_reg       <= DIV_W'(job.start);
            dsr_reg       <= DIV_W'(cfg.blk) << (IDX_W - 1);
            q_reg         <= '0;
            bit_cnt_reg   <= CNT_W'(IDX_W - 1);
        end
        else if (state_reg == B_DIVIDE)
        begin
            if (ge_c)
            begin
                rem_reg <= diff_c;
            end
            dsr_reg     <= dsr_reg >> 1;
            q_reg       <= {q_reg[IDX_W-2:0], ge_c};
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
        end
        else if (state_reg == B_ALIGN)
        begin
            oib_reg    <= OIB_W'(rem_reg);
            bstart_reg <= start_reg - OFF_W'(rem_reg);
        end
        else if (load_seg)
        begin
            remaining_reg <= rem_after_c;
            q_reg         <= q_reg + 1'b1;
            bstart_reg    <= bstart_reg + OFF_W'(cfg.blk);
            oib_reg       <= '0;
        end

        if (load_single)
        begin
            out_index_reg <= '0;
            out_oib_reg   <= '0;
            out_last_reg  <= 1'b1;
            case (job.kind)
                K_ERROR:
                begin
                    out_status_reg <= ST_BEYOND_END;
                    out_action_reg <= ACT_CACHED;
                    out_foff_reg   <= '0;
                    out_flen_reg   <= '0;
                    out_seg_reg    <= '0;
                end
                K_CAPACITY:
                begin
                    out_status_reg <= ST_NO_CAPACITY;
                    out_action_reg <= ACT_CACHED;
                    out_foff_reg   <= '0;
                    out_flen_reg   <= '0;
                    out_seg_reg    <= '0;
                end
                K_BYPASS:
                begin
                    out_status_reg <= ST_OK;
                    out_action_reg <= ACT_BYPASS;
                    out_foff_reg   <= job.start;
                    out_flen_reg   <= BLK_W'(job.len);
                    out_seg_reg    <= job.len;
                end
                default:
                begin
                    out_status_reg <= ST_OK;
                    out_action_reg <= ACT_CACHED;
                    out_foff_reg   <= '0;
                    out_flen_reg   <= '0;
                    out_seg_reg    <= '0;
                end
            endcase
        end
        else if (load_seg)
        begin
            out_status_reg <= ST_OK;
            out_action_reg <= present ? ACT_CACHED : ACT_FILL;
            out_index_reg  <= q_reg;
            out_foff_reg   <= present ? '0 : bstart_reg;
            out_flen_reg   <= present ? '0 : flen_c;
            out_oib_reg    <= oib_reg;
            out_seg_reg    <= seg_c;
            out_last_reg   <= (rem_after_c == '0);
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (load_single || load_seg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.status          = out_status_reg;
    assign res.action          = out_action_reg;
    assign res.block_num       = out_index_reg;
    assign res.fill_offset     = out_foff_reg;
    assign res.fill_length     = out_flen_reg;
    assign res.offset_in_block = out_oib_reg;
    assign res.segment_length  = out_seg_reg;
    assign res.last            = out_last_reg;

endmodule

// ----- rtl/block_cache_read_splitter.sv -----
// ============================================================================
// block_cache_read_splitter
// Split file read requests into per-block cache segments.
// ============================================================================
// Usage:
//   req: one read request per transaction (start_offset, length).
//   res: one or more results per request; last marks the final one.
//   cfg: register writes (index 0 file_length, 1 block_bytes,
//        2 jump_tolerance, 3 near_window); always ready, write only while idle.
// Flow:
//   The front accepts a request, compares it against the window, classifies
//   it and hands a job to a two-entry queue, taking no new request until the
//   job is pushed. An error, bypass, empty or capacity verdict is loaded into
//   the output register at the edge where the back pops it. A split request
//   runs through the bit-serial divider (one quotient bit per cycle, one per
//   block index bit), an align step, then per touched block a presence RAM
//   read and an emit and set step that waits for a free output register.
//   The back pops no new job until a split item, up to 33 segments, is done.
// Reset:
//   Registers take their defaults and the presence RAM is swept clear, one
//   entry per cycle, all 65536 entries; req.ready stays low meanwhile.
// Stalls:
//   A stalled res holds the output register and the back; the queue absorbs
//   up to two classified requests, the front holds one more and then stops.
// ============================================================================
module block_cache_read_splitter import bcrs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    bcrs_cfg_if.sink   cfg,
    bcrs_req_if.sink   req,
    bcrs_res_if.source res
);

    logic [FLEN_W-1:0] file_length_reg;
    logic [BLK_W-1:0]  block_bytes_reg;
    logic [TOL_W-1:0]  jump_tol_reg;
    logic [NW_W-1:0]   near_window_reg;

    cfg_t              cfg_eff;
    logic              front_enable;
    logic              fq_valid;
    logic              fq_ready;
    job_t              fq_job;
    logic              qb_valid;
    logic              qb_ready;
    job_t              qb_job;

    // the port never stalls a register write
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
            block_bytes_reg <= DEFAULT_BLOCK;
            jump_tol_reg    <= DEFAULT_TOL;
            near_window_reg <= DEFAULT_NEAR;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FILE_LENGTH:    file_length_reg <= FLEN_W'(cfg.data);
                REG_BLOCK_BYTES:    block_bytes_reg <= BLK_W'(cfg.data);
                REG_JUMP_TOLERANCE: jump_tol_reg    <= TOL_W'(cfg.data);
                REG_NEAR_WINDOW:    near_window_reg <= NW_W'(cfg.data);
                default:
                begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    // clamp block size into the supported range
    always_comb
    begin
        cfg_eff.file_length = file_length_reg;
        cfg_eff.tol         = jump_tol_reg;
        cfg_eff.near_window = near_window_reg;
        if (block_bytes_reg < MIN_BLOCK)
        begin
            cfg_eff.blk = MIN_BLOCK;
        end
        else if (block_bytes_reg > MAX_BLOCK)
        begin
            cfg_eff.blk = MAX_BLOCK;
        end
        else
        begin
            cfg_eff.blk = block_bytes_reg;
        end
    end

    bcrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_eff),
        .enable    (front_enable),
        .req       (req),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    bcrs_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_job)
    );

    bcrs_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg_eff),
        .ready_for_requests (front_enable),
        .job_valid          (qb_valid),
        .job_ready          (qb_ready),
        .job                (qb_job),
        .res                (res)
    );

endmodule
